### rtl/vbsp_pkg.sv
// Shared types and constants for the block stream parser.
// Used by the front parser, the token queue, the back end and the top level.
package vbsp_pkg;

  localparam logic [7:0]  SYNC_A     = 8'hAA;
  localparam logic [7:0]  SYNC_B     = 8'h55;
  localparam logic [7:0]  COLOR_B    = 8'h56;
  localparam logic [15:0] HDR_NORMAL = 16'hAA55;
  localparam logic [15:0] HDR_COLOR  = 16'hAA56;

  localparam logic [2:0] SLOT_SUM = 3'd0;
  localparam logic [2:0] SLOT_SIG = 3'd1;
  localparam logic [2:0] SLOT_X   = 3'd2;
  localparam logic [2:0] SLOT_Y   = 3'd3;
  localparam logic [2:0] SLOT_W   = 3'd4;
  localparam logic [2:0] SLOT_H   = 3'd5;
  localparam logic [2:0] SLOT_ANG = 3'd6;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_HDR_A,
    PH_HDR_B,
    PH_WHI,
    PH_WLO
  } phase_t;

  // One assembled word, tagged by the front with its place in the block.
  typedef struct packed {
    logic [2:0]  slot;
    logic [15:0] word;
    logic        color;
    logic        last;
  } word_tok_t;

  typedef struct packed {
    logic               block_kind;
    logic [15:0]        object_signature;
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic signed [15:0] rotation;
    logic [15:0]        sent_sum;
    logic               sum_status;
    logic [31:0]        good_total;
    logic [31:0]        bad_total;
  } result_t;

endpackage

### rtl/vbsp_front.sv
// Front end: byte-level frame and header parser that assembles words.
// Depends on vbsp_pkg; feeds word tokens into vbsp_tok_queue.
module vbsp_front
  import vbsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      byte_vld,
  input  logic [7:0] byte_in,
  output logic      tok_push,
  output word_tok_t tok
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic       color_r, color_nxt;
  logic       retaken_r, retaken_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic [15:0] w;
  logic [2:0]  last_slot;

  assign w         = {hi_r, byte_in};
  assign last_slot = color_r ? SLOT_ANG : SLOT_H;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      hi_r      <= '0;
      color_r   <= 1'b0;
      retaken_r <= 1'b0;
      slot_r    <= SLOT_SUM;
    end else begin
      phase_r   <= phase_nxt;
      hi_r      <= hi_nxt;
      color_r   <= color_nxt;
      retaken_r <= retaken_nxt;
      slot_r    <= slot_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    hi_nxt      = hi_r;
    color_nxt   = color_r;
    retaken_nxt = retaken_r;
    slot_nxt    = slot_r;
    tok_push    = 1'b0;
    tok.slot    = slot_r;
    tok.word    = w;
    tok.color   = color_r;
    tok.last    = (slot_r == last_slot);
    if (byte_vld) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (byte_in == SYNC_A) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_nxt = (byte_in == SYNC_B) ? PH_HDR_A : PH_HUNT;
        end
        PH_HDR_A: begin
          phase_nxt = (byte_in == SYNC_A) ? PH_HDR_B : PH_HUNT;
        end
        PH_HDR_B: begin
          if (byte_in == SYNC_B || byte_in == COLOR_B) begin
            color_nxt   = (byte_in == COLOR_B);
            retaken_nxt = 1'b0;
            slot_nxt    = SLOT_SUM;
            phase_nxt   = PH_WHI;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_WHI: begin
          hi_nxt    = byte_in;
          phase_nxt = PH_WLO;
        end
        PH_WLO: begin
          phase_nxt = PH_WHI;
          if (slot_r == SLOT_SUM) begin
            // A header word in the checksum place restarts the block once.
            if (!retaken_r && (w == HDR_NORMAL || w == HDR_COLOR)) begin
              retaken_nxt = 1'b1;
              color_nxt   = (w == HDR_COLOR);
            end else begin
              tok_push = 1'b1;
              slot_nxt = SLOT_SIG;
            end
          end else begin
            tok_push = 1'b1;
            if (slot_r == last_slot) begin
              slot_nxt    = SLOT_SUM;
              retaken_nxt = 1'b0;
              phase_nxt   = PH_HDR_A;
            end else begin
              slot_nxt = slot_r + 3'd1;
            end
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

endmodule

### rtl/vbsp_tok_queue.sv
// Two-entry queue of word tokens between the front parser and the back end.
// Depends on vbsp_pkg for the token type.
module vbsp_tok_queue
  import vbsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  word_tok_t push_tok,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output word_tok_t head
);

  word_tok_t  ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_r] <= push_tok;
  end

endmodule

### rtl/vbsp_back.sv
// Back end: stores block words, checks the additive checksum, keeps the
// saturating totals and holds finished results in a two-entry output queue.
// Depends on vbsp_pkg.
module vbsp_back
  import vbsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tok_empty,
  input  word_tok_t tok,
  output logic      tok_pop,
  output logic      res_empty,
  input  logic      res_pop,
  output result_t   res
);

  logic [15:0] sum_w_r, sig_r, x_r, y_r, wd_r, ht_r;
  logic [15:0] run_r, run_nxt;
  logic [31:0] good_r, bad_r, good_nxt, bad_nxt;
  logic        bad;
  result_t     fin;

  result_t    q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       q_push, q_pop;

  // A token is taken only when its result, if any, has a place to go.
  assign tok_pop = !tok_empty && (cnt_r != 2'd2);
  assign run_nxt = run_r + tok.word;
  assign bad     = (run_nxt != sum_w_r);
  assign good_nxt = (!bad && good_r != 32'hFFFF_FFFF) ? good_r + 32'd1 : good_r;
  assign bad_nxt  = (bad && bad_r != 32'hFFFF_FFFF) ? bad_r + 32'd1 : bad_r;

  always_comb begin
    fin.block_kind       = tok.color;
    fin.object_signature = sig_r;
    fin.center_x         = x_r;
    fin.center_y         = y_r;
    fin.box_width        = wd_r;
    fin.box_height       = ht_r;
    fin.rotation         = '0;
    fin.sent_sum         = sum_w_r;
    fin.sum_status       = bad;
    fin.good_total       = good_nxt;
    fin.bad_total        = bad_nxt;
    // The last word is taken straight from the token here, not from a register.
    case (tok.slot)
      SLOT_H:   fin.box_height = tok.word;
      SLOT_ANG: fin.rotation   = tok.word;
      default:  fin.box_height = ht_r;
    endcase
  end

  assign q_push    = tok_pop && (tok.slot != SLOT_SUM) && tok.last;
  assign q_pop     = res_pop && !res_empty;
  assign res_empty = (cnt_r == 2'd0);
  assign res       = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      good_r <= '0;
      bad_r  <= '0;
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (tok_pop) begin
        if (tok.slot == SLOT_SUM) begin
          run_r <= '0;
        end else begin
          run_r <= run_nxt;
        end
      end
      if (q_push) begin
        good_r <= good_nxt;
        bad_r  <= bad_nxt;
        wr_r   <= ~wr_r;
      end
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      case (tok.slot)
        SLOT_SUM: sum_w_r <= tok.word;
        SLOT_SIG: sig_r   <= tok.word;
        SLOT_X:   x_r     <= tok.word;
        SLOT_Y:   y_r     <= tok.word;
        SLOT_W:   wd_r    <= tok.word;
        SLOT_H:   ht_r    <= tok.word;
        default: ;
      endcase
    end
    if (q_push) q_r[wr_r] <= fin;
  end

endmodule

### rtl/vision_block_stream_parser.sv
// Top level of the block stream parser: front parser, token queue, back end.
// Depends on vbsp_pkg, vbsp_front, vbsp_tok_queue and vbsp_back.
//
// One received byte is taken per beat, and a new byte is accepted every
// cycle while in_full is low. The front parser finds the frame sync and
// block headers and builds 16-bit words; each word passes through a
// two-entry queue to the back end, which stores it and, on the last word
// of a block, checks the checksum and writes one result into a two-entry
// output queue, whose head is shown on the out_ ports. Input is refused
// only when the token queue is full, which happens only when results
// are not being popped.
module vision_block_stream_parser
  import vbsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_block_kind,
  output logic [15:0]        out_object_signature,
  output logic [15:0]        out_center_x,
  output logic [15:0]        out_center_y,
  output logic [15:0]        out_box_width,
  output logic [15:0]        out_box_height,
  output logic signed [15:0] out_rotation,
  output logic [15:0]        out_sent_sum,
  output logic               out_sum_status,
  output logic [31:0]        out_good_total,
  output logic [31:0]        out_bad_total
);

  logic      tq_full, tq_empty, tq_pop, f_push;
  word_tok_t f_tok, tq_head;
  result_t   res;

  vbsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (in_push && !in_full),
    .byte_in  (in_rx_byte),
    .tok_push (f_push),
    .tok      (f_tok)
  );

  vbsp_tok_queue u_tq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_tok (f_tok),
    .full     (tq_full),
    .pop      (tq_pop),
    .empty    (tq_empty),
    .head     (tq_head)
  );

  vbsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_empty (tq_empty),
    .tok       (tq_head),
    .tok_pop   (tq_pop),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res       (res)
  );

  assign in_full              = tq_full;
  assign out_block_kind       = res.block_kind;
  assign out_object_signature = res.object_signature;
  assign out_center_x         = res.center_x;
  assign out_center_y         = res.center_y;
  assign out_box_width        = res.box_width;
  assign out_box_height       = res.box_height;
  assign out_rotation         = res.rotation;
  assign out_sent_sum         = res.sent_sum;
  assign out_sum_status       = res.sum_status;
  assign out_good_total       = res.good_total;
  assign out_bad_total        = res.bad_total;

endmodule

### dv/testbench.sv
// Self-checking testbench for vision_block_stream_parser: byte stimulus, a parser
// predictor and a result checker that compares every popped block field by field.
// Depends on vbsp_pkg and the RTL of the block stream parser.
module testbench;
  import vbsp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_pop = 1'b0;
  logic               in_full;
  logic               out_empty;
  logic               out_block_kind;
  logic [15:0]        out_object_signature;
  logic [15:0]        out_center_x;
  logic [15:0]        out_center_y;
  logic [15:0]        out_box_width;
  logic [15:0]        out_box_height;
  logic signed [15:0] out_rotation;
  logic [15:0]        out_sent_sum;
  logic               out_sum_status;
  logic [31:0]        out_good_total;
  logic [31:0]        out_bad_total;

  vision_block_stream_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_rx_byte           (in_rx_byte),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_block_kind       (out_block_kind),
    .out_object_signature (out_object_signature),
    .out_center_x         (out_center_x),
    .out_center_y         (out_center_y),
    .out_box_width        (out_box_width),
    .out_box_height       (out_box_height),
    .out_rotation         (out_rotation),
    .out_sent_sum         (out_sent_sum),
    .out_sum_status       (out_sum_status),
    .out_good_total       (out_good_total),
    .out_bad_total        (out_bad_total)
  );

  always #2 clk = ~clk;

  // Predicted parser state, starting from the reset values.
  phase_t      frame_phase = PH_HUNT;
  logic [7:0]  high_byte = 8'h00;
  logic        color_block = 1'b0;
  logic        header_again = 1'b0;
  logic [2:0]  word_idx = SLOT_SUM;
  logic [15:0] block_word [7];
  logic [15:0] data_sum = 16'h0000;
  logic [31:0] good_blocks = 32'd0;
  logic [31:0] bad_blocks = 32'd0;
  result_t     expected_blocks [$];
  result_t     oldest_block;

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  bit pop_hold = 1'b0;
  int bytes_sent = 0;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic void parse_byte(input logic [7:0] b);
    logic [15:0] w;
    logic [2:0]  last_idx;
    result_t     r;
    w = {high_byte, b};
    case (frame_phase)
      PH_HUNT: if (b == SYNC_A) frame_phase = PH_SYNC2;
      PH_SYNC2: frame_phase = (b == SYNC_B) ? PH_HDR_A : PH_HUNT;
      PH_HDR_A: frame_phase = (b == SYNC_A) ? PH_HDR_B : PH_HUNT;
      PH_HDR_B: begin
        if (b == SYNC_B || b == COLOR_B) begin
          color_block = (b == COLOR_B);
          header_again = 1'b0;
          word_idx = SLOT_SUM;
          data_sum = 16'h0000;
          frame_phase = PH_WHI;
        end else begin
          frame_phase = PH_HUNT;
        end
      end
      PH_WHI: begin
        high_byte = b;
        frame_phase = PH_WLO;
      end
      PH_WLO: begin
        frame_phase = PH_WHI;
        if (word_idx == SLOT_SUM) begin
          // A header word in the checksum slot restarts the block once.
          if (!header_again && (w == HDR_NORMAL || w == HDR_COLOR)) begin
            header_again = 1'b1;
            color_block = (w == HDR_COLOR);
          end else begin
            block_word[SLOT_SUM] = w;
            word_idx = SLOT_SIG;
          end
        end else begin
          block_word[word_idx] = w;
          data_sum = data_sum + w;
          last_idx = color_block ? SLOT_ANG : SLOT_H;
          if (word_idx != last_idx) begin
            word_idx = word_idx + 3'd1;
          end else begin
            r.block_kind       = color_block;
            r.object_signature = block_word[SLOT_SIG];
            r.center_x         = block_word[SLOT_X];
            r.center_y         = block_word[SLOT_Y];
            r.box_width        = block_word[SLOT_W];
            r.box_height       = block_word[SLOT_H];
            r.rotation         = color_block ? block_word[SLOT_ANG] : 16'h0000;
            r.sent_sum         = block_word[SLOT_SUM];
            r.sum_status       = (data_sum != block_word[SLOT_SUM]);
            if (r.sum_status) begin
              if (bad_blocks != 32'hFFFF_FFFF) bad_blocks = bad_blocks + 32'd1;
            end else begin
              if (good_blocks != 32'hFFFF_FFFF) good_blocks = good_blocks + 32'd1;
            end
            r.good_total = good_blocks;
            r.bad_total  = bad_blocks;
            expected_blocks.push_back(r);
            word_idx = SLOT_SUM;
            header_again = 1'b0;
            frame_phase = PH_HDR_A;
          end
        end
      end
      default: frame_phase = PH_HUNT;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_blocks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result beat with no block expected: signature %h", out_object_signature);
      end else begin
        oldest_block = expected_blocks.pop_front();
        compare_field("block_kind", 32'(oldest_block.block_kind), 32'(out_block_kind));
        compare_field("object_signature", 32'(oldest_block.object_signature),
                      32'(out_object_signature));
        compare_field("center_x", 32'(oldest_block.center_x), 32'(out_center_x));
        compare_field("center_y", 32'(oldest_block.center_y), 32'(out_center_y));
        compare_field("box_width", 32'(oldest_block.box_width), 32'(out_box_width));
        compare_field("box_height", 32'(oldest_block.box_height), 32'(out_box_height));
        compare_field("rotation", {16'h0000, oldest_block.rotation},
                      {16'h0000, out_rotation});
        compare_field("sent_sum", 32'(oldest_block.sent_sum), 32'(out_sent_sum));
        compare_field("sum_status", 32'(oldest_block.sum_status), 32'(out_sum_status));
        compare_field("good_total", oldest_block.good_total, out_good_total);
        compare_field("bad_total", oldest_block.bad_total, out_bad_total);
      end
    end
  end

  always @(negedge clk)
    out_pop <= rst_n && !pop_hold && ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("testbench failed");
          $finish;
        end
      end
    end
  end

  // Offers one byte, possibly after idle cycles, and returns once the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  function automatic logic [15:0] pick_word(input int fill);
    logic [15:0] v;
    case (fill)
      FILL_ZERO: v = 16'h0000;
      FILL_ONES: v = 16'hFFFF;
      default: begin
        case ($urandom_range(9))
          0: v = 16'h0000;
          1: v = 16'hFFFF;
          default: v = 16'($urandom_range(65535));
        endcase
      end
    endcase
    return v;
  endfunction

  // Sends one block with its header. With two header words in the checksum
  // slot, the second one stands as the checksum.
  task automatic send_block(input bit hdr_color, input int retakes, input bit sum_ok,
                            input int fill);
    logic [15:0] data [6];
    logic [15:0] total;
    logic [15:0] chk;
    logic [15:0] off;
    logic [15:0] retake_word;
    bit          color;
    int          n;
    color = hdr_color;
    total = 16'h0000;
    retake_word = HDR_NORMAL;
    send_byte(SYNC_A);
    send_byte(hdr_color ? COLOR_B : SYNC_B);
    for (int i = 0; i < retakes; i++) begin
      retake_word = $urandom_range(1) ? HDR_COLOR : HDR_NORMAL;
      if (i == 0) color = (retake_word == HDR_COLOR);
      send_word(retake_word);
    end
    n = color ? 6 : 5;
    for (int i = 0; i < n; i++) begin
      data[i] = pick_word(fill);
      total = total + data[i];
    end
    off = 16'($urandom_range(65535, 1));
    if (retakes >= 2) begin
      chk = retake_word;
      if (sum_ok) data[n-1] = data[n-1] + chk - total;
    end else begin
      chk = sum_ok ? total : total + off;
      send_word(chk);
    end
    for (int i = 0; i < n; i++) send_word(data[i]);
  endtask

  function automatic int pick_retakes();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return 2;
    if (roll < 20) return 1;
    return 0;
  endfunction

  task automatic send_noise(input int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(9);
      if (roll < 3) send_byte(SYNC_A);
      else if (roll < 4) send_byte(SYNC_B);
      else if (roll < 5) send_byte(COLOR_B);
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  // A frame is the sync pair, some blocks, and then one of several ways to end.
  task automatic send_frame(input int blocks);
    logic [7:0] b;
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    repeat (blocks) send_block(1'($urandom_range(1)), pick_retakes(),
                               $urandom_range(3) != 0, FILL_RANDOM);
    case ($urandom_range(3))
      0: begin
        do b = 8'($urandom_range(255)); while (b == SYNC_A);
        send_byte(b);
      end
      1: begin
        send_byte(SYNC_A);
        do b = 8'($urandom_range(255)); while (b == SYNC_B || b == COLOR_B);
        send_byte(b);
      end
      2: send_noise($urandom_range(4, 1));
      default: ;
    endcase
  endtask

  task automatic test_sync_errors();
    send_byte(8'h00);
    // Wrong second sync byte, even 0xAA, is consumed.
    send_byte(SYNC_A);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    // Synced, then a non-header byte ends the frame.
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'h12);
    // Synced, then a header with a bad second byte.
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(SYNC_A);
    send_byte(8'h57);
  endtask

  task automatic test_block_extremes();
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_block(1'b0, 0, 1'b1, FILL_ZERO);
    send_block(1'b1, 0, 1'b0, FILL_ONES);
    send_block(1'b0, 1, 1'b1, FILL_RANDOM);
    send_block(1'b1, 2, 1'b0, FILL_RANDOM);
    send_byte(8'hFF);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    pop_hold = 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        pop_hold = 1'b0;
      end
      send_frame(6);
    join
  endtask

  task automatic test_random_stream(input int send_idle, input int pop_stall,
                                    input int n_bytes);
    int stop_at;
    send_idle_pct = send_idle;
    pop_stall_pct = pop_stall;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(4) != 0) send_frame($urandom_range(4, 1));
      else send_noise($urandom_range(12, 1));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_sync_errors();
    test_block_extremes();
    test_backpressure();
    test_random_stream(0, 0, 380);
    test_random_stream(55, 0, 380);
    test_random_stream(0, 55, 380);
    test_random_stream(34, 34, 380);
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_blocks.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
